// File: rtl/npcm_pkg.sv
// Shared types and constants for the nearest palette color match unit.
`timescale 1ns / 1ps

package npcm_pkg;

  localparam int COLOR_W = 8;
  localparam int IDX_W   = 12;
  localparam int DIST_W  = 9;
  localparam int CNT_W   = 13;
  localparam int SQ_W    = 2 * COLOR_W;
  localparam int SUM_W   = 18;
  localparam int REM_W   = 11;

  localparam logic [DIST_W-1:0] MAX_DIST = 9'd441;

  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic               action;
    logic [IDX_W-1:0]   entry_index;
    logic [COLOR_W-1:0] red;
    logic [COLOR_W-1:0] green;
    logic [COLOR_W-1:0] blue;
  } in_item_t;

  typedef struct packed {
    logic [IDX_W-1:0]  best_index;
    logic [DIST_W-1:0] best_distance;
  } out_item_t;

endpackage

// File: rtl/nearest_palette_color_match_unit.sv
// Top level: palette store, scan sequencer, distance pipeline and best-match tracking.
//
//  channel | signals                          | dir | payload
//  --------+----------------------------------+-----+---------------------------------
//  input   | in_valid / in_ready / in_item    | in  | action, entry_index, red/green/blue
//  output  | out_valid / out_ready / out_item | out | best_index, best_distance
//  config  | cfg_wr_en / cfg_wr_data          | in  | entries_in_use (13 bits)
//
//  A load item writes the palette memory at the accept edge.
//  A query offers its result once its scan of N entries drains (N = entries searched,
//  a count of 0 searches one); the next item follows the registered result: one palette
//  read per cycle, then the 2-stage distance path, the 9-stage square root and compare.
//  Reset (rst, synchronous) clears control only; the palette is undefined until loaded.
//  A finished result sits in the output register; if it is still held when the next
//  query ends, that query waits in DONE until the output slot frees.
`timescale 1ns / 1ps

module nearest_palette_color_match_unit #(
  parameter int PALETTE_DEPTH = 4096
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  npcm_pkg::in_item_t                   in_item,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output npcm_pkg::out_item_t                  out_item,
  input  logic                                 cfg_wr_en,
  input  logic [npcm_pkg::CNT_W-1:0]           cfg_wr_data
);

  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int TAG_W = AW + 1;
  localparam int CW    = npcm_pkg::COLOR_W;
  localparam int PW    = 3 * CW;

  typedef enum logic [1:0] {
    IDLE,
    SCAN,
    DRAIN,
    DONE
  } state_t;

  state_t state;

  // configuration
  logic [npcm_pkg::CNT_W-1:0] entries_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      entries_in_use <= npcm_pkg::CNT_W'(1);
    end else if (cfg_wr_en) begin
      entries_in_use <= cfg_wr_data;
    end
  end

  // input decode
  logic        in_acc;
  logic        load_acc;
  logic        query_acc;
  logic [31:0] load_idx32;
  logic        load_ok;
  logic [31:0] cnt32;
  logic [31:0] last32;

  always_comb begin
    in_acc     = in_valid && in_ready;
    load_acc   = in_acc && (in_item.action == npcm_pkg::ACT_LOAD);
    query_acc  = in_acc && (in_item.action == npcm_pkg::ACT_QUERY);
    load_idx32 = 32'(in_item.entry_index);
    load_ok    = load_idx32 < 32'(PALETTE_DEPTH);
    cnt32      = 32'(entries_in_use);
    // zero counts as one entry; counts past the depth saturate
    if (cnt32 == 32'd0) begin
      last32 = 32'd0;
    end else if (cnt32 > 32'(PALETTE_DEPTH)) begin
      last32 = 32'(PALETTE_DEPTH) - 32'd1;
    end else begin
      last32 = cnt32 - 32'd1;
    end
  end

  // query context, latched at accept
  logic [CW-1:0] px_red;
  logic [CW-1:0] px_green;
  logic [CW-1:0] px_blue;
  logic [AW-1:0] last_addr;
  logic [AW-1:0] scan_addr;

  always_ff @(posedge clk) begin
    if (query_acc) begin
      px_red    <= in_item.red;
      px_green  <= in_item.green;
      px_blue   <= in_item.blue;
      last_addr <= last32[AW-1:0];
    end
  end

  // palette memory
  logic          scan_issue;
  logic          scan_last;
  logic [PW-1:0] rd_color;

  assign scan_issue = (state == SCAN);
  assign scan_last  = (scan_addr == last_addr);

  npcm_palette_ram #(
    .DEPTH (PALETTE_DEPTH),
    .AW    (AW),
    .DW    (PW)
  ) u_ram (
    .clk   (clk),
    .we    (load_acc && load_ok),
    .waddr (load_idx32[AW-1:0]),
    .wdata ({in_item.red, in_item.green, in_item.blue}),
    .re    (scan_issue),
    .raddr (scan_addr),
    .rdata (rd_color)
  );

  // distance pipeline: read -> squares -> sum -> sqrt -> compare
  logic                        rd_vld;
  logic [TAG_W-1:0]            rd_tag;
  logic                        sq_vld;
  logic [TAG_W-1:0]            sq_tag;
  logic [npcm_pkg::SQ_W-1:0]   sq_r;
  logic [npcm_pkg::SQ_W-1:0]   sq_g;
  logic [npcm_pkg::SQ_W-1:0]   sq_b;
  logic                        sum_vld;
  logic [TAG_W-1:0]            sum_tag;
  logic [npcm_pkg::SUM_W-1:0]  sum_sq;
  logic [CW-1:0]               dr;
  logic [CW-1:0]               dg;
  logic [CW-1:0]               db;

  always_comb begin
    dr = (px_red > rd_color[PW-1 -: CW]) ? px_red - rd_color[PW-1 -: CW]
                                         : rd_color[PW-1 -: CW] - px_red;
    dg = (px_green > rd_color[2*CW-1 -: CW]) ? px_green - rd_color[2*CW-1 -: CW]
                                             : rd_color[2*CW-1 -: CW] - px_green;
    db = (px_blue > rd_color[CW-1:0]) ? px_blue - rd_color[CW-1:0]
                                      : rd_color[CW-1:0] - px_blue;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_vld  <= 1'b0;
      sq_vld  <= 1'b0;
      sum_vld <= 1'b0;
    end else begin
      rd_vld  <= scan_issue;
      sq_vld  <= rd_vld;
      sum_vld <= sq_vld;
    end
    rd_tag  <= {scan_last, scan_addr};
    sq_tag  <= rd_tag;
    sq_r    <= npcm_pkg::SQ_W'(dr) * npcm_pkg::SQ_W'(dr);
    sq_g    <= npcm_pkg::SQ_W'(dg) * npcm_pkg::SQ_W'(dg);
    sq_b    <= npcm_pkg::SQ_W'(db) * npcm_pkg::SQ_W'(db);
    sum_tag <= sq_tag;
    sum_sq  <= npcm_pkg::SUM_W'(sq_r) + npcm_pkg::SUM_W'(sq_g) + npcm_pkg::SUM_W'(sq_b);
  end

  logic                         rt_vld;
  logic [npcm_pkg::DIST_W-1:0]  rt_root;
  logic [TAG_W-1:0]             rt_tag;

  npcm_sqrt_pipe #(
    .TAG_W (TAG_W)
  ) u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .in_vld   (sum_vld),
    .in_rad   (sum_sq),
    .in_tag   (sum_tag),
    .out_vld  (rt_vld),
    .out_root (rt_root),
    .out_tag  (rt_tag)
  );

  // best-match tracking; entry 0 always seeds, later entries must be strictly closer
  logic [AW-1:0]               best_idx;
  logic [npcm_pkg::DIST_W-1:0] best_dist;
  logic                        rt_first;
  logic                        rt_is_last;
  logic                        rt_better;
  logic [31:0]                 best_idx32;

  always_comb begin
    rt_first   = (rt_tag[AW-1:0] == '0);
    rt_is_last = rt_tag[AW];
    rt_better  = rt_first || (rt_root < best_dist);
    best_idx32 = 32'(best_idx);
  end

  always_ff @(posedge clk) begin
    if (rt_vld && rt_better) begin
      best_idx  <= rt_tag[AW-1:0];
      best_dist <= rt_root;
    end
  end

  // sequencer and output register
  assign in_ready = (state == IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      scan_addr <= '0;
      out_valid <= 1'b0;
    end else begin
      // DONE refills the slot itself when it frees
      if (out_valid && out_ready && (state != DONE)) begin
        out_valid <= 1'b0;
      end
      case (state)
        IDLE: begin
          scan_addr <= '0;
          if (query_acc) begin
            state <= SCAN;
          end
        end
        SCAN: begin
          if (scan_last) begin
            state <= DRAIN;
          end else begin
            scan_addr <= scan_addr + AW'(1);
          end
        end
        DRAIN: begin
          if (rt_vld && rt_is_last) begin
            state <= DONE;
          end
        end
        DONE: begin
          if (!out_valid || out_ready) begin
            out_valid              <= 1'b1;
            out_item.best_index    <= best_idx32[npcm_pkg::IDX_W-1:0];
            out_item.best_distance <= best_dist;
            state                  <= IDLE;
          end
        end
        default: begin
          state <= IDLE;
        end
      endcase
    end
  end

`ifndef ASSERT_OFF
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == SCAN) |-> (scan_addr <= last_addr))
    else $error("scan address ran past the last entry in use");

  a_query_starts_scan: assert property (@(posedge clk) disable iff (rst)
    query_acc |=> (state == SCAN))
    else $error("accepted query did not start a scan");

  a_root_only_in_query: assert property (@(posedge clk) disable iff (rst)
    rt_vld |-> (state == SCAN || state == DRAIN))
    else $error("distance result outside an active query");

  a_dist_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_item.best_distance <= npcm_pkg::MAX_DIST))
    else $error("best distance above the RGB maximum");
`endif

endmodule

// File: rtl/npcm_palette_ram.sv
// Palette color memory: one write port, one registered read port.
`timescale 1ns / 1ps

module npcm_palette_ram #(
  parameter int DEPTH = 4096,
  parameter int AW    = 12,
  parameter int DW    = 24
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: rtl/npcm_sqrt_pipe.sv
// Pipelined integer square root, one root bit per stage, with a side tag.
`timescale 1ns / 1ps

module npcm_sqrt_pipe #(
  parameter int TAG_W = 13
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_vld,
  input  logic [npcm_pkg::SUM_W-1:0]       in_rad,
  input  logic [TAG_W-1:0]                 in_tag,
  output logic                             out_vld,
  output logic [npcm_pkg::DIST_W-1:0]      out_root,
  output logic [TAG_W-1:0]                 out_tag
);

  localparam int NST = npcm_pkg::DIST_W;
  localparam int RW  = npcm_pkg::REM_W;
  localparam int SW  = RW + 2;

  logic                         st_vld  [0:NST];
  logic [TAG_W-1:0]             st_tag  [0:NST];
  logic [NST-1:0]               st_root [0:NST];
  logic [RW-1:0]                st_rem  [0:NST-1];
  logic [npcm_pkg::SUM_W-1:0]   st_rad  [0:NST-1];

  assign st_vld[0]  = in_vld;
  assign st_tag[0]  = in_tag;
  assign st_root[0] = '0;
  assign st_rem[0]  = '0;
  assign st_rad[0]  = in_rad;

  for (genvar k = 0; k < NST; k++) begin : g_stage
    localparam int BI = NST - 1 - k;
    logic [SW-1:0] rem_sh;
    logic [SW-1:0] trial;
    logic [SW:0]   diff;
    logic          ge;

    always_comb begin
      rem_sh = {st_rem[k], st_rad[k][2*BI+1 -: 2]};
      trial  = SW'({st_root[k], 2'b01});
      diff   = {1'b0, rem_sh} - {1'b0, trial};
      ge     = ~diff[SW];
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        st_vld[k+1] <= 1'b0;
      end else begin
        st_vld[k+1] <= st_vld[k];
      end
      st_tag[k+1]  <= st_tag[k];
      st_root[k+1] <= {st_root[k][NST-2:0], ge};
    end

    if (k < NST - 1) begin : g_carry
      always_ff @(posedge clk) begin
        st_rem[k+1] <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
        st_rad[k+1] <= st_rad[k];
      end
    end
  end

  assign out_vld  = st_vld[NST];
  assign out_root = st_root[NST];
  assign out_tag  = st_tag[NST];

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the nearest palette color match unit.
`timescale 1ns / 1ps

module testbench;

  localparam int DEPTH       = 4096;
  localparam int FILLED      = 32;     // entries 0..FILLED-1 are written before random phases
  localparam int SETTLE      = 24;     // quiet cycles before a register write and at the end
  localparam int STALL_LIMIT = 20000;  // cycles with no item moving on either channel
  localparam int REPORT_MAX  = 10;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  npcm_pkg::in_item_t in_item = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  npcm_pkg::out_item_t out_item;
  logic cfg_wr_en = 1'b0;
  logic [npcm_pkg::CNT_W-1:0] cfg_wr_data = '0;

  // Shadow of the block state: palette colors as {red, green, blue} and the search count.
  logic [3*npcm_pkg::COLOR_W-1:0] palette_shadow [DEPTH];
  logic [npcm_pkg::CNT_W-1:0] search_count = npcm_pkg::CNT_W'(1);

  npcm_pkg::in_item_t  items_to_send [$];     // filled by the stimulus block, drained by driver
  npcm_pkg::out_item_t expected_matches [$];  // one entry per accepted query, oldest first

  int items_queued = 0;  // stimulus block only
  int items_taken  = 0;  // monitor only
  int mismatches   = 0;
  int quiet_cycles = 0;
  bit in_taken  = 1'b0;  // item accepted at the last rising edge
  bit out_taken = 1'b0;
  int send_gap = 0, send_calm = 0;
  int recv_stall = 0, recv_calm = 0;

  nearest_palette_color_match_unit #(
    .PALETTE_DEPTH(DEPTH)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_item     (in_item),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_item    (out_item),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Mostly short idle stretches, now and then a long one.
  function automatic int draw_gap();
    int pick = $urandom_range(0, 99);
    if (pick < 50) return 0;
    if (pick < 85) return $urandom_range(1, 3);
    if (pick < 96) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Floored Euclidean RGB distance; root built bit by bit from the top (max 441 < 512).
  function automatic int unsigned color_gap(logic [npcm_pkg::COLOR_W-1:0] r,
                                            logic [npcm_pkg::COLOR_W-1:0] g,
                                            logic [npcm_pkg::COLOR_W-1:0] b,
                                            logic [3*npcm_pkg::COLOR_W-1:0] entry);
    int unsigned dr, dg, db, sum, root, trial;
    dr = (r > entry[23:16]) ? r - entry[23:16] : entry[23:16] - r;
    dg = (g > entry[15:8])  ? g - entry[15:8]  : entry[15:8]  - g;
    db = (b > entry[7:0])   ? b - entry[7:0]   : entry[7:0]   - b;
    sum = dr * dr + dg * dg + db * db;
    root = 0;
    for (int k = 8; k >= 0; k--) begin
      trial = root | (1 << k);
      if (trial * trial <= sum) root = trial;
    end
    return root;
  endfunction

  // Scan entries from zero; only a strictly smaller floored distance replaces the best,
  // so ties stay with the lower index. Count 0 searches one entry, big counts saturate.
  function automatic npcm_pkg::out_item_t nearest_entry(logic [npcm_pkg::COLOR_W-1:0] r,
                                                        logic [npcm_pkg::COLOR_W-1:0] g,
                                                        logic [npcm_pkg::COLOR_W-1:0] b);
    int unsigned span, cand_gap;
    npcm_pkg::out_item_t best;
    span = (search_count == 0) ? 1 : (search_count > DEPTH) ? DEPTH : search_count;
    best.best_index    = '0;
    best.best_distance = npcm_pkg::DIST_W'(color_gap(r, g, b, palette_shadow[0]));
    for (int unsigned j = 1; j < span; j++) begin
      cand_gap = color_gap(r, g, b, palette_shadow[j]);
      if (cand_gap < best.best_distance) begin
        best.best_index    = npcm_pkg::IDX_W'(j);
        best.best_distance = npcm_pkg::DIST_W'(cand_gap);
      end
    end
    return best;
  endfunction

  // Monitor: sample both channels at the rising edge, predict on input, check on output.
  always @(posedge clk) begin : monitor
    npcm_pkg::out_item_t want;
    in_taken  <= !rst && in_valid && in_ready;
    out_taken <= !rst && out_valid && out_ready;
    if (!rst) begin
      if (in_valid && in_ready) begin
        items_taken++;
        if (in_item.action == npcm_pkg::ACT_LOAD)
          palette_shadow[in_item.entry_index] = {in_item.red, in_item.green, in_item.blue};
        else
          expected_matches.push_back(nearest_entry(in_item.red, in_item.green, in_item.blue));
      end
      if (out_valid && out_ready) begin
        if (expected_matches.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("%0t: result with no query pending: index %0d distance %0d",
                     $realtime, out_item.best_index, out_item.best_distance);
        end else begin
          want = expected_matches.pop_front();
          if (out_item.best_index !== want.best_index ||
              out_item.best_distance !== want.best_distance) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("%0t: index exp %0d got %0d, distance exp %0d got %0d", $realtime,
                       want.best_index, out_item.best_index,
                       want.best_distance, out_item.best_distance);
          end
        end
      end
      // Watchdog: a full 4096-entry scan plus output stalls stays well under the limit.
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("end of test: mismatches");
        $finish;
      end
    end
  end

  // Input driver: holds an item until accepted, then idles for a drawn gap.
  always @(negedge clk) begin
    if (!rst && !(in_valid && !in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (items_to_send.size() != 0) begin
        in_item  <= items_to_send.pop_front();
        in_valid <= 1'b1;
        if (send_calm > 0) begin
          send_calm--;
          send_gap = 0;
        end else begin
          send_gap = draw_gap();
          if ($urandom_range(0, 19) == 0) send_calm = $urandom_range(10, 40);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result receiver: stalls after a result and sometimes out of the blue.
  always @(negedge clk) begin
    if (!rst) begin
      if (out_taken) begin
        if (recv_calm > 0) begin
          recv_calm--;
          recv_stall = 0;
        end else begin
          recv_stall = draw_gap();
          if ($urandom_range(0, 19) == 0) recv_calm = $urandom_range(10, 40);
        end
      end else if (recv_stall == 0 && recv_calm == 0 && $urandom_range(0, 49) == 0) begin
        recv_stall = draw_gap();
      end
      if (recv_stall > 0) begin
        recv_stall--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic queue_item(logic act, int unsigned idx, logic [npcm_pkg::COLOR_W-1:0] r,
                            logic [npcm_pkg::COLOR_W-1:0] g,
                            logic [npcm_pkg::COLOR_W-1:0] b);
    npcm_pkg::in_item_t it;
    it.action      = act;
    it.entry_index = npcm_pkg::IDX_W'(idx);
    it.red         = r;
    it.green       = g;
    it.blue        = b;
    items_to_send.push_back(it);
    items_queued++;
  endtask

  // Everything sent is accepted and answered; then let the block settle.
  task automatic wait_idle();
    do @(negedge clk); while (items_taken != items_queued || expected_matches.size() != 0);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_search_count(int unsigned value);
    wait_idle();
    cfg_wr_en    <= 1'b1;
    cfg_wr_data  <= npcm_pkg::CNT_W'(value);
    search_count = npcm_pkg::CNT_W'(value);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  // Color level with extra weight on the extremes.
  function automatic logic [npcm_pkg::COLOR_W-1:0] pick_level();
    int p = $urandom_range(0, 9);
    if (p == 0) return '0;
    if (p == 1) return '1;
    return npcm_pkg::COLOR_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [npcm_pkg::COLOR_W-1:0] nudge(logic [npcm_pkg::COLOR_W-1:0] c);
    int v = int'(c) + $urandom_range(0, 4) - 2;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return npcm_pkg::COLOR_W'(v);
  endfunction

  // Loads mostly land in the searched range; queries are random pixels, exact copies of
  // searched entries, or near misses that make truncated-distance ties likely.
  task automatic random_phase(int n_items, int unsigned span);
    int kind;
    int unsigned idx;
    logic [3*npcm_pkg::COLOR_W-1:0] near;
    for (int i = 0; i < n_items; i++) begin
      kind = $urandom_range(0, 99);
      near = palette_shadow[$urandom_range(0, span - 1)];
      if (kind < 40) begin
        idx = ($urandom_range(0, 2) != 0) ? $urandom_range(0, span - 1)
                                          : $urandom_range(0, DEPTH - 1);
        queue_item(npcm_pkg::ACT_LOAD, idx, pick_level(), pick_level(), pick_level());
      end else if (kind < 60) begin
        queue_item(npcm_pkg::ACT_QUERY, $urandom_range(0, DEPTH - 1),
                   pick_level(), pick_level(), pick_level());
      end else if (kind < 80) begin
        queue_item(npcm_pkg::ACT_QUERY, $urandom_range(0, DEPTH - 1),
                   near[23:16], near[15:8], near[7:0]);
      end else begin
        queue_item(npcm_pkg::ACT_QUERY, $urandom_range(0, DEPTH - 1),
                   nudge(near[23:16]), nudge(near[15:8]), nudge(near[7:0]));
      end
    end
  endtask

  initial begin
    int unsigned count;
    int pick;

    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Reset count of one: black and white extremes, maximum distance 441.
    // Queries carry junk entry_index values, which must be ignored.
    queue_item(npcm_pkg::ACT_LOAD,  0,         8'd0,   8'd0,   8'd0);
    queue_item(npcm_pkg::ACT_QUERY, DEPTH - 1, 8'd255, 8'd255, 8'd255);
    queue_item(npcm_pkg::ACT_QUERY, 0,         8'd0,   8'd0,   8'd0);
    queue_item(npcm_pkg::ACT_LOAD,  0,         8'd255, 8'd255, 8'd255);
    queue_item(npcm_pkg::ACT_QUERY, 2730,      8'd0,   8'd0,   8'd0);

    // Zero count searches entry 0 only: the exact match in entry 1 must not win.
    write_search_count(0);
    queue_item(npcm_pkg::ACT_LOAD,  1,    8'd0, 8'd0, 8'd0);
    queue_item(npcm_pkg::ACT_QUERY, 1365, 8'd0, 8'd0, 8'd0);

    // Four entries: floored distances sqrt(2) and 1 tie at 1 (lower index wins),
    // duplicate colors tie at 0, and the last loaded entry must be searched.
    write_search_count(4);
    queue_item(npcm_pkg::ACT_LOAD,  0, 8'd11,  8'd11,  8'd10);
    queue_item(npcm_pkg::ACT_LOAD,  1, 8'd11,  8'd10,  8'd10);
    queue_item(npcm_pkg::ACT_LOAD,  2, 8'd11,  8'd10,  8'd10);
    queue_item(npcm_pkg::ACT_LOAD,  3, 8'd200, 8'd100, 8'd50);
    queue_item(npcm_pkg::ACT_QUERY, 0, 8'd10,  8'd10,  8'd10);
    queue_item(npcm_pkg::ACT_QUERY, 0, 8'd11,  8'd10,  8'd10);
    queue_item(npcm_pkg::ACT_QUERY, 0, 8'd200, 8'd100, 8'd50);
    queue_item(npcm_pkg::ACT_QUERY, 0, 8'd255, 8'd0,   8'd128);

    // Fill the low part of the palette so every count up to FILLED searches written entries.
    for (int i = 4; i < FILLED; i++)
      queue_item(npcm_pkg::ACT_LOAD, i, pick_level(), pick_level(), pick_level());

    // Random phases, mostly short scans, now and then a longer one up to the filled range.
    repeat (4) begin
      pick = $urandom_range(0, 99);
      if (pick < 10)      count = 0;
      else if (pick < 20) count = 1;
      else if (pick < 80) count = $urandom_range(2, 16);
      else                count = $urandom_range(17, FILLED);
      write_search_count(count);
      random_phase(24, (count == 0) ? 1 : count);
    end

    wait_idle();
    if (mismatches == 0)
      $display("end of test: clean");
    else
      $display("end of test: mismatches");
    $finish;
  end

endmodule
